@@ src/kepler_equation_solver_assert.svh @@
// Assertion macros for the Kepler solver checker.
// Depends on nothing; included by files that assert.
`ifndef KEPLER_EQUATION_SOLVER_ASSERT_SVH
`define KEPLER_EQUATION_SOLVER_ASSERT_SVH

// implication checked while out of reset
`define KES_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked while out of reset
`define KES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication checked at all times
`define KES_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/kes_pkg.sv @@
// Shared constants, register indexes and arithmetic helpers for the Kepler solver.
// No dependencies.
`default_nettype none
package kes_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_METHOD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 2'd2;

  localparam int CFG_DATA_W = 28;
  localparam int ANG_W  = 32;
  localparam int ECC_W  = 30;
  localparam int TOL_W  = 28;
  localparam int ITER_W = 8;

  localparam int OP_W   = 36;
  localparam int PROD_W = 2 * OP_W;
  localparam int NUM_W  = 64;
  localparam int DEN_W  = 36;

  localparam int CA_W = 35;
  localparam int CX_W = 34;

  localparam logic signed [CA_W-1:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [CA_W-1:0] Q30_TWO_PI  = 35'sd6746518852;
  localparam logic signed [CA_W-1:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [CX_W-1:0] Q30_GAIN    = 34'sd652032874;
  localparam logic signed [CX_W-1:0] Q30_ONE     = 34'sd1073741824;

  localparam logic method_newton = 1'b0;

  function automatic logic signed [CA_W-1:0] atan_step(input logic [5:0] i);
    logic signed [CA_W-1:0] r;
    case (i)
      6'd0:  r = 35'sd843314857;
      6'd1:  r = 35'sd497837829;
      6'd2:  r = 35'sd263043837;
      6'd3:  r = 35'sd133525159;
      6'd4:  r = 35'sd67021687;
      6'd5:  r = 35'sd33543516;
      6'd6:  r = 35'sd16775851;
      6'd7:  r = 35'sd8388437;
      6'd8:  r = 35'sd4194283;
      6'd9:  r = 35'sd2097149;
      6'd10: r = 35'sd1048576;
      default: begin
        if (i <= 6'd30) r = 35'sd1 <<< (6'd30 - i);
        else r = '0;
      end
    endcase
    return r;
  endfunction

  function automatic logic signed [PROD_W-1:0] rnd_shift(
      input logic signed [PROD_W-1:0] v, input int unsigned s);
    logic signed [PROD_W-1:0] b;
    b = 72'sd1 <<< (s - 1);
    return (v + b) >>> s;
  endfunction

  function automatic logic signed [ANG_W-1:0] sat32(input logic signed [64:0] v);
    logic signed [ANG_W-1:0] r;
    if (v > 65'sd2147483647) r = 32'sh7fffffff;
    else if (v < -65'sd2147483648) r = 32'sh80000000;
    else r = v[ANG_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/kes_cordic.sv @@
// Rotation-mode CORDIC giving sine and cosine of a Q4.28 angle in Q.30.
// One micro-rotation per cycle after range reduction. Uses kes_pkg.
`default_nettype none
module kes_cordic #(
  parameter int CORDIC_STEPS = 30
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [kes_pkg::ANG_W-1:0]  angle,
  output logic                                   done,
  output logic signed [kes_pkg::CX_W-1:0]        sin_out,
  output logic signed [kes_pkg::CX_W-1:0]        cos_out
);
  import kes_pkg::*;

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_RED  = 2'd1;
  localparam logic [1:0] C_FOLD = 2'd2;
  localparam logic [1:0] C_RUN  = 2'd3;

  logic [1:0]             state;
  logic signed [CA_W-1:0] a;
  logic signed [CX_W-1:0] x, y, xs, ys;
  logic                   flip;
  logic [IW-1:0]          i;
  logic signed [CA_W-1:0] at;

  assign xs = x >>> i;
  assign ys = y >>> i;
  assign at = atan_step(6'(i));
  assign sin_out = y;
  assign cos_out = flip ? -x : x;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            a     <= {angle[ANG_W-1], angle, 2'b00};
            state <= C_RED;
          end
        end
        C_RED: begin
          if (a > Q30_PI) a <= a - Q30_TWO_PI;
          else if (a < -Q30_PI) a <= a + Q30_TWO_PI;
          state <= C_FOLD;
        end
        C_FOLD: begin
          flip <= 1'b0;
          if (a > Q30_HALF_PI) begin
            a    <= Q30_PI - a;
            flip <= 1'b1;
          end else if (a < -Q30_HALF_PI) begin
            a    <= -Q30_PI - a;
            flip <= 1'b1;
          end
          x     <= Q30_GAIN;
          y     <= '0;
          i     <= '0;
          state <= C_RUN;
        end
        C_RUN: begin
          if (!a[CA_W-1]) begin
            x <= x - ys;
            y <= y + xs;
            a <= a - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            a <= a + at;
          end
          if (i == IW'(CORDIC_STEPS - 1)) begin
            done  <= 1'b1;
            state <= C_IDLE;
          end else begin
            i <= i + 1'b1;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ src/kes_mul.sv @@
// Shared signed multiplier with a registered product.
// Uses kes_pkg widths.
`default_nettype none
module kes_mul (
  input  wire logic                              clk,
  input  wire logic signed [kes_pkg::OP_W-1:0]   op_a,
  input  wire logic signed [kes_pkg::OP_W-1:0]   op_b,
  output logic signed [kes_pkg::PROD_W-1:0]      prod
);
  import kes_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(op_a) * PROD_W'(op_b);
  end
endmodule
`default_nettype wire

@@ src/kes_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Uses kes_pkg widths.
`default_nettype none
module kes_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [kes_pkg::NUM_W-1:0]  num,
  input  wire logic signed [kes_pkg::DEN_W-1:0]  den,
  output logic                                   done,
  output logic signed [kes_pkg::NUM_W-1:0]       quo
);
  import kes_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic              busy;
  logic              neg;
  logic [NUM_W-1:0]  nm;
  logic [DEN_W-1:0]  dm;
  logic [DEN_W-1:0]  rem;
  logic [CW-1:0]     cnt;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem, nm[NUM_W-1]};
  assign fits  = trial >= {1'b0, dm};
  assign quo   = neg ? -$signed(nm) : $signed(nm);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        neg  <= num[NUM_W-1] ^ den[DEN_W-1];
        nm   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        dm   <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        rem  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        if (fits) rem <= DEN_W'(trial - {1'b0, dm});
        else rem <= trial[DEN_W-1:0];
        nm <= {nm[NUM_W-2:0], fits};
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ src/kepler_equation_solver.sv @@
// Kepler equation solver top level: register file, sequencer, output register.
// Depends on kes_pkg, kes_cordic, kes_mul, kes_div.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one item: mean_anomaly (Q4.28)
//   and eccentricity (Q0.30). Output channel (out_valid/out_ready) returns
//   eccentric_anomaly (Q4.28, saturated) and converged.
//   One item is in work at a time; in_ready is high only while the sequencer
//   is idle. The output register holds a finished item, so a new item may be
//   taken while the receiver stalls; the next result waits in the sequencer
//   until the output register is free.
//   The starting guess takes one CORDIC pass; each refinement step then takes
//   a CORDIC pass plus one division (Newton mode) or up to two divisions
//   (Householder mode, the second only when its denominator is nonzero) on
//   the shared divider; the divide by six is a reciprocal multiply. The
//   output register is loaded last.
//   Up to min(max_iterations, ITERATION_BOUND) steps run.
//   Configuration (cfg_we, cfg_index, cfg_data) is to be written by the user
//   only while idle; the block does not enforce this. Reset restores method,
//   tolerance and max_iterations to their defaults and empties the block.
`default_nettype none
module kepler_equation_solver #(
  parameter int ITERATION_BOUND = 255,
  parameter int CORDIC_STEPS    = 30
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [kes_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [kes_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [kes_pkg::ANG_W-1:0]       mean_anomaly,
  input  wire logic [kes_pkg::ECC_W-1:0]              eccentricity,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [kes_pkg::ANG_W-1:0]            eccentric_anomaly,
  output logic                                        converged
);
  import kes_pkg::*;

  localparam int KW = $clog2(ITERATION_BOUND + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_TRIG0 = 5'd1;
  localparam logic [4:0] S_INIT  = 5'd2;
  localparam logic [4:0] S_ITER  = 5'd3;
  localparam logic [4:0] S_TRIG  = 5'd4;
  localparam logic [4:0] S_ESIN  = 5'd5;
  localparam logic [4:0] S_ECOS  = 5'd6;
  localparam logic [4:0] S_DM    = 5'd7;
  localparam logic [4:0] S_HST   = 5'd8;
  localparam logic [4:0] S_HDIV  = 5'd9;
  localparam logic [4:0] S_HC    = 5'd10;
  localparam logic [4:0] S_T1    = 5'd11;
  localparam logic [4:0] S_H2    = 5'd12;
  localparam logic [4:0] S_H2B   = 5'd13;
  localparam logic [4:0] S_T2    = 5'd14;
  localparam logic [4:0] S_T6    = 5'd15;
  localparam logic [4:0] S_NUM   = 5'd16;
  localparam logic [4:0] S_HN    = 5'd17;
  localparam logic [4:0] S_SDIV  = 5'd18;
  localparam logic [4:0] S_UPD   = 5'd19;
  localparam logic [4:0] S_DONE  = 5'd20;
  localparam logic [4:0] S_T6Q   = 5'd21;

  // ceil(2^36 / 6): exact truncating divide by six for magnitudes below 2^33
  localparam logic signed [OP_W-1:0] RECIP_SIX = 36'sd11453246123;
  localparam int RECIP_SHIFT = 36;

  logic                 method;
  logic [TOL_W-1:0]     tolerance;
  logic [ITER_W-1:0]    max_iterations;

  logic [4:0]              state;
  logic signed [ANG_W-1:0] m, ea;
  logic [ECC_W-1:0]        ecc;
  logic [KW-1:0]           lim, k;
  logic                    meth, conv;
  logic [TOL_W-1:0]        tol;
  logic signed [CX_W-1:0]  esin, ecos, fp;
  logic signed [CA_W-1:0]  dm;
  logic signed [NUM_W-1:0] h, step;
  logic signed [30:0]      hc;
  logic signed [DEN_W-1:0] t1, h2, num, den;
  logic [32:0]             t2_mag;
  logic                    t2_neg;

  logic                    cor_start, cor_done;
  logic signed [ANG_W-1:0] cor_angle;
  logic signed [CX_W-1:0]  cor_sin, cor_cos;
  logic signed [OP_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod, p_r32, p_r30, p_r28;
  logic                    div_start, div_done;
  logic signed [NUM_W-1:0] div_num, div_quo;
  logic signed [DEN_W-1:0] div_den;

  logic                    accept;
  logic signed [OP_W-1:0]  ecc_op;
  logic signed [CA_W-1:0]  dm_next, dm_clamp, dm_abs;
  logic signed [CA_W-1:0]  esin_rnd;
  logic signed [CA_W-1:0]  fp_raw;
  logic signed [NUM_W-1:0] h_clamp;
  logic signed [ANG_W-1:0] ea_next;
  logic [KW:0]             k_inc;
  logic signed [DEN_W-1:0] t2_val, t2_q, t2_quo;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign ecc_op   = $signed({{(OP_W-ECC_W){1'b0}}, ecc});

  assign p_r32 = rnd_shift(prod, 32);
  assign p_r30 = rnd_shift(prod, 30);
  assign p_r28 = rnd_shift(prod, 28);

  assign esin_rnd = (CA_W'(esin) + 35'sd2) >>> 2;
  assign dm_next  = CA_W'(m) - (CA_W'(ea) - esin_rnd);
  assign fp_raw   = CA_W'(Q30_ONE) - CA_W'(ecos);
  assign dm_clamp = (dm > 35'sd4294967296) ? 35'sd4294967296 :
                    (dm < -35'sd4294967296) ? -35'sd4294967296 : dm;
  assign dm_abs   = dm[CA_W-1] ? -dm : dm;
  assign h_clamp  = (div_quo > 64'sd536870912) ? 64'sd536870912 :
                    (div_quo < -64'sd536870912) ? -64'sd536870912 : div_quo;
  assign ea_next  = sat32(65'(ea) + 65'(step));
  assign k_inc    = {1'b0, k} + 1'b1;

  assign t2_val = p_r28[DEN_W-1:0];
  assign t2_q   = $signed(prod[PROD_W-1:RECIP_SHIFT]);
  assign t2_quo = t2_neg ? -t2_q : t2_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      method         <= 1'b1;
      tolerance      <= TOL_W'(1);
      max_iterations <= ITER_W'(128);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_METHOD:    method         <= cfg_data[0];
        CFG_TOLERANCE: tolerance      <= cfg_data[TOL_W-1:0];
        CFG_MAX_ITER:  max_iterations <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cor_start = 1'b0;
    cor_angle = mean_anomaly;
    if (accept) begin
      cor_start = 1'b1;
    end else if (state == S_ITER) begin
      cor_start = 1'b1;
      cor_angle = ea;
    end
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_TRIG0, S_TRIG: begin
        op_a = ecc_op;
        op_b = OP_W'(cor_sin);
      end
      S_ESIN: begin
        op_a = ecc_op;
        op_b = OP_W'(cor_cos);
      end
      S_HC: begin
        op_a = OP_W'(esin);
        op_b = OP_W'(hc);
      end
      S_T1: begin
        op_a = OP_W'(hc);
        op_b = OP_W'(hc);
      end
      S_H2B: begin
        op_a = OP_W'(ecos);
        op_b = h2;
      end
      S_T6: begin
        op_a = $signed({3'b0, t2_mag});
        op_b = RECIP_SIX;
      end
      S_NUM: begin
        op_a = OP_W'(hc);
        op_b = num;
      end
      default: ;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      S_HST: begin
        div_start = 1'b1;
        div_num   = NUM_W'(dm_clamp) <<< 30;
        div_den   = DEN_W'(fp);
      end
      S_HN: begin
        div_start = (den != '0);
        div_num   = prod[NUM_W-1:0];
        div_den   = den;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            m    <= mean_anomaly;
            ecc  <= eccentricity;
            meth <= method;
            tol  <= tolerance;
            conv <= 1'b0;
            if (32'(max_iterations) > ITERATION_BOUND) lim <= KW'(ITERATION_BOUND);
            else lim <= KW'(max_iterations);
            state <= S_TRIG0;
          end
        end
        S_TRIG0: if (cor_done) state <= S_INIT;
        S_INIT: begin
          ea <= sat32(65'(m) + 65'(p_r32));
          k  <= '0;
          if (lim == '0) state <= S_DONE;
          else state <= S_ITER;
        end
        S_ITER: state <= S_TRIG;
        S_TRIG: if (cor_done) state <= S_ESIN;
        S_ESIN: begin
          esin  <= p_r30[CX_W-1:0];
          state <= S_ECOS;
        end
        S_ECOS: begin
          ecos  <= p_r30[CX_W-1:0];
          state <= S_DM;
        end
        S_DM: begin
          dm    <= dm_next;
          fp    <= (fp_raw < 35'sd1) ? 34'sd1 : fp_raw[CX_W-1:0];
          state <= S_HST;
        end
        S_HST: state <= S_HDIV;
        S_HDIV: begin
          if (div_done) begin
            h    <= div_quo;
            hc   <= h_clamp[30:0];
            step <= div_quo;
            if (meth == method_newton) state <= S_UPD;
            else state <= S_HC;
          end
        end
        S_HC: state <= S_T1;
        S_T1: begin
          t1    <= p_r28[DEN_W-1:0];
          state <= S_H2;
        end
        S_H2: begin
          h2    <= p_r28[DEN_W-1:0];
          state <= S_H2B;
        end
        S_H2B: state <= S_T2;
        S_T2: begin
          t2_neg <= t2_val[DEN_W-1];
          t2_mag <= t2_val[DEN_W-1] ? 33'(-t2_val) : t2_val[32:0];
          state  <= S_T6;
        end
        S_T6: state <= S_T6Q;
        S_T6Q: begin
          den   <= DEN_W'(fp) + t1 + t2_quo;
          num   <= DEN_W'(fp) + (t1 >>> 1);
          state <= S_NUM;
        end
        S_NUM: state <= S_HN;
        S_HN: begin
          if (den == '0) begin
            step  <= h;
            state <= S_UPD;
          end else begin
            state <= S_SDIV;
          end
        end
        S_SDIV: begin
          if (div_done) begin
            step  <= div_quo;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          ea <= ea_next;
          if (dm_abs < $signed({7'b0, tol})) begin
            conv  <= 1'b1;
            state <= S_DONE;
          end else if (k_inc == {1'b0, lim}) begin
            state <= S_DONE;
          end else begin
            k     <= k_inc[KW-1:0];
            state <= S_ITER;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            eccentric_anomaly <= ea;
            converged         <= conv;
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  kes_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .angle   (cor_angle),
    .done    (cor_done),
    .sin_out (cor_sin),
    .cos_out (cor_cos)
  );

  kes_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  kes_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule
`default_nettype wire

@@ src/kes_checker.sv @@
// Port-level checks for the Kepler solver, bound to the top level.
// Depends on kes_pkg and kepler_equation_solver_assert.svh.
`default_nettype none
`include "kepler_equation_solver_assert.svh"
module kes_port_checker (
  input wire logic                                   clk,
  input wire logic                                   rst,
  input wire logic                                   cfg_we,
  input wire logic [kes_pkg::CFG_IDX_W-1:0]          cfg_index,
  input wire logic [kes_pkg::CFG_DATA_W-1:0]         cfg_data,
  input wire logic                                   in_valid,
  input wire logic                                   in_ready,
  input wire logic signed [kes_pkg::ANG_W-1:0]       mean_anomaly,
  input wire logic [kes_pkg::ECC_W-1:0]              eccentricity,
  input wire logic                                   out_valid,
  input wire logic                                   out_ready,
  input wire logic signed [kes_pkg::ANG_W-1:0]       eccentric_anomaly,
  input wire logic                                   converged
);
  import kes_pkg::*;

  logic unused_ok;
  assign unused_ok = cfg_we ^ (^cfg_index) ^ (^cfg_data) ^ (^mean_anomaly) ^ (^eccentricity);

  `KES_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(eccentric_anomaly) && $stable(converged), "output item changed while stalled")
  `KES_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "accepted a second item while busy")
  `KES_ASSERT_ALWAYS_NEXT(a_reset_idle, clk, rst, !out_valid && in_ready, "not empty after reset")
  `KES_ASSERT_IMPLY(a_ready_known, clk, rst, !in_ready, !(in_valid && in_ready), "accept without ready")

endmodule

bind kepler_equation_solver kes_port_checker u_kes_checker (
  .clk               (clk),
  .rst               (rst),
  .cfg_we            (cfg_we),
  .cfg_index         (cfg_index),
  .cfg_data          (cfg_data),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .mean_anomaly      (mean_anomaly),
  .eccentricity      (eccentricity),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .eccentric_anomaly (eccentric_anomaly),
  .converged         (converged)
);
`default_nettype wire

@@ bench/kes_checker.sv @@
`timescale 1ns / 100ps
// Checker for the Kepler equation solver: tracks register writes, predicts each
// solution from accepted items and compares it with the output channel. Uses kes_pkg.
module kes_checker
  import kes_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic signed [ANG_W-1:0] mean_anomaly,
  input  logic [ECC_W-1:0]        eccentricity,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [ANG_W-1:0] eccentric_anomaly,
  input  logic                    converged,
  output int                      fail_count,
  output int                      pending
);

  localparam int ROTATIONS = 30;
  localparam int STEP_BOUND = 255;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30 = 64'sd652032874;

  typedef struct packed {
    logic signed [ANG_W-1:0] anomaly;
    logic                    conv;
  } solution_t;

  solution_t solutions_due[$];
  logic              method_q;
  logic [TOL_W-1:0]  tolerance_q;
  logic [ITER_W-1:0] iterations_q;

  assign pending = solutions_due.size();

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint saturate(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint limit_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint arctan_q30(int i);
    longint tbl[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
    if (i < 11) return tbl[i];
    if (i <= 30) return 64'sd1 <<< (30 - i);
    return 0;
  endfunction

  function automatic void sin_cos(input longint angle, output longint sn, output longint cs);
    longint a, x, y, t;
    bit flip;
    a = angle * 4;
    x = GAIN_Q30;
    y = 0;
    flip = 0;
    while (a > PI_Q30) a -= 2 * PI_Q30;
    while (a < -PI_Q30) a += 2 * PI_Q30;
    if (a > HALF_PI_Q30) begin
      a = PI_Q30 - a;
      flip = 1;
    end else if (a < -HALF_PI_Q30) begin
      a = -PI_Q30 - a;
      flip = 1;
    end
    for (int i = 0; i < ROTATIONS; i++) begin
      if (a >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        a -= arctan_q30(i);
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        a += arctan_q30(i);
      end
      x = t;
    end
    sn = y;
    cs = flip ? -x : x;
  endfunction

  function automatic solution_t solve_anomaly(logic signed [ANG_W-1:0] m_in,
                                              logic [ECC_W-1:0] e_in);
    longint m, e, ea, sn, cs, esin, ecos, dm, fp, h, stp, hc, t1, h2, t2, num, den, mag;
    int lim;
    solution_t r;
    m = m_in;
    e = e_in;
    lim = (iterations_q > STEP_BOUND) ? STEP_BOUND : iterations_q;
    r.conv = 0;
    sin_cos(m, sn, cs);
    ea = saturate(m + round_shift(e * sn, 32));
    for (int k = 0; k < lim; k++) begin
      sin_cos(ea, sn, cs);
      esin = round_shift(e * sn, 30);
      ecos = round_shift(e * cs, 30);
      dm = m - (ea - round_shift(esin, 2));
      fp = ONE_Q30 - ecos;
      if (fp < 1) fp = 1;
      h = (limit_mag(dm, 64'sd1 <<< 32) * ONE_Q30) / fp;
      if (method_q == method_newton) begin
        stp = h;
      end else begin
        hc = limit_mag(h, 64'sd1 <<< 29);
        t1 = round_shift(esin * hc, 28);
        h2 = round_shift(hc * hc, 28);
        t2 = round_shift(ecos * h2, 28);
        num = fp + (t1 >>> 1);
        den = fp + t1 + t2 / 6;
        stp = (den == 0) ? h : (hc * num) / den;
      end
      ea = saturate(ea + stp);
      mag = dm < 0 ? -dm : dm;
      if (mag < longint'(tolerance_q)) begin
        r.conv = 1;
        break;
      end
    end
    r.anomaly = ea[ANG_W-1:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    solution_t want;
    if (rst) begin
      method_q <= 1'b1;
      tolerance_q <= 28'd1;
      iterations_q <= 8'd128;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_METHOD:    method_q <= cfg_data[0];
          CFG_TOLERANCE: tolerance_q <= cfg_data[TOL_W-1:0];
          CFG_MAX_ITER:  iterations_q <= cfg_data[ITER_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        solutions_due.push_back(solve_anomaly(mean_anomaly, eccentricity));
      if (out_valid && out_ready) begin
        if (solutions_due.size() == 0) begin
          fail_count <= fail_count + 1;
          $display("%0t: unexpected item E=%0d converged=%0b", $time,
                   eccentric_anomaly, converged);
        end else begin
          want = solutions_due.pop_front();
          if (want.anomaly !== eccentric_anomaly || want.conv !== converged) begin
            fail_count <= fail_count + 1;
            $display("%0t: expected E=%0d converged=%0b, actual E=%0d converged=%0b",
                     $time, want.anomaly, want.conv, eccentric_anomaly, converged);
          end
        end
      end
    end
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Top of the Kepler solver bench: clock, reset, register phases, item stimulus
// and verdict. Depends on kes_pkg, kepler_equation_solver and kes_checker.
module testbench;
  import kes_pkg::*;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [ANG_W-1:0] mean_anomaly;
  logic [ECC_W-1:0]        eccentricity;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [ANG_W-1:0] eccentric_anomaly;
  logic                    converged;
  int                      fail_count;
  int                      pending;
  bit                      calm;
  int                      stall_left;

  localparam logic [ECC_W-1:0] ECC_TOP = '1;
  localparam logic signed [ANG_W-1:0] PI_Q28 = 32'sd843314857;

  kepler_equation_solver i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mean_anomaly(mean_anomaly),
    .eccentricity(eccentricity), .out_valid(out_valid), .out_ready(out_ready),
    .eccentric_anomaly(eccentric_anomaly), .converged(converged)
  );

  kes_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mean_anomaly(mean_anomaly),
    .eccentricity(eccentricity), .out_valid(out_valid), .out_ready(out_ready),
    .eccentric_anomaly(eccentric_anomaly), .converged(converged),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("testbench: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst || calm) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(3) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic mode, logic [TOL_W-1:0] tol, logic [ITER_W-1:0] iters);
    write_reg(CFG_METHOD, CFG_DATA_W'(mode));
    write_reg(CFG_TOLERANCE, tol);
    write_reg(CFG_MAX_ITER, CFG_DATA_W'(iters));
  endtask

  task automatic send_item(logic signed [ANG_W-1:0] m, logic [ECC_W-1:0] e);
    if (!calm && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mean_anomaly <= m;
    eccentricity <= e;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [ANG_W-1:0] pick_anomaly();
    case ($urandom_range(3))
      0: return $urandom_range(2 * PI_Q28) - PI_Q28;
      1: return $urandom_range(65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ECC_W-1:0] pick_eccentricity();
    case ($urandom_range(4))
      0: return ECC_TOP - ECC_W'($urandom_range(1000));
      1: return ECC_W'($urandom_range(1000));
      default: return ECC_W'($urandom);
    endcase
  endfunction

  function automatic logic [TOL_W-1:0] pick_tolerance();
    case ($urandom_range(5))
      0: return TOL_W'(0);
      1: return TOL_W'(1);
      2: return '1;
      3: return TOL_W'($urandom_range(4095));
      default: return TOL_W'($urandom_range(1 << 20));
    endcase
  endfunction

  initial begin
    logic signed [ANG_W-1:0] corner_m[8];
    logic [ECC_W-1:0] corner_e[3];
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 0;
    mean_anomaly = '0;
    eccentricity = '0;
    calm = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset settings: few items, tolerance 1 may run the full limit
    send_item(32'sd100000000, 30'd200000000);
    send_item(32'sd0, 30'd0);
    drain();

    corner_m = '{32'sh7fffffff, 32'sh80000000, 32'sd0, PI_Q28, -PI_Q28,
                 PI_Q28 / 2, 32'sd1, -32'sd1};
    corner_e = '{30'd0, ECC_TOP, 30'd536870912};
    for (int mode = 0; mode < 2; mode++) begin
      configure(mode[0], 28'd256, 8'd6);
      foreach (corner_m[i])
        send_item(corner_m[i], corner_e[i % 3]);
      send_item(32'sd1000, ECC_TOP);
      send_item(32'sd5000000, ECC_TOP - 30'd1);
      drain();
    end

    configure(1'b0, 28'd0, 8'd0);
    send_item(32'sd123456789, 30'd600000000);
    send_item(-32'sd98765432, ECC_TOP);
    drain();
    configure(1'b1, 28'd0, 8'd255);
    send_item(32'sh7fffffff, ECC_TOP);
    drain();
    configure(1'b0, 28'hfffffff, 8'd255);
    send_item(-32'sd300000000, 30'd900000000);
    drain();

    for (int phase = 0; phase < 13; phase++) begin
      calm = (phase == 12);
      configure($urandom_range(1), pick_tolerance(), ITER_W'($urandom_range(6)));
      repeat (115) send_item(pick_anomaly(), pick_eccentricity());
      drain();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/kes_pkg.sv
src/kes_cordic.sv
src/kes_mul.sv
src/kes_div.sv
src/kepler_equation_solver.sv
src/kes_checker.sv
bench/kes_checker.sv
bench/testbench.sv
